>>> sv/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

>>> sv/rgtd_pkg.sv
// Types, constants and the character cleanup function of the RDS group text decoder.
package rgtd_pkg;

  typedef logic [7:0] char_t;

  localparam int InW       = 112;
  localparam int OutW      = 184;
  localparam int TextChars = 64;
  localparam int RowChars  = 8;
  localparam int Rows      = TextChars / RowChars;

  localparam char_t ChNul   = 8'h00;
  localparam char_t ChLf    = 8'h0A;
  localparam char_t ChCr    = 8'h0D;
  localparam char_t ChSpace = 8'h20;
  localparam char_t ChDot   = 8'h2E;
  localparam char_t ChTilde = 8'h7E;

  localparam logic [3:0] GrpPs = 4'd0;
  localparam logic [3:0] GrpRt = 4'd2;

  function automatic char_t clean_char(char_t v);
    char_t r;
    if (v == ChNul || v == ChCr || v == ChLf) begin
      r = ChNul;
    end else if (v >= ChSpace && v <= ChTilde) begin
      r = v;
    end else begin
      r = ChSpace;
    end
    return r;
  endfunction

endpackage

>>> sv/rds_group_text_decoder_core.sv
// RDS group decoder: PS name and radiotext store, one group in, eight slice beats out.
//
// A group with block A or B missing is dropped in its accepting cycle (no beats).
// Otherwise it goes through the accepting cycle, the three bit-serial quality dividers
// (one per block B, C, D) and the merge step, the read-modify-write pass over the 8 rows
// of the radiotext memory, a finishing step, and the emit pass, in which each output
// beat takes a memory read, then an output register load; the emit pass can stall while
// m_axis_tready is low. Input is taken only while the block is idle. Output beats carry
// slice 0..7; tlast marks slice 7.
module rds_group_text_decoder_core #(
  parameter int CONF_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // block_a, block_b, block_c, block_d, received_flags, error_flags,
  // corrected_counts, confidence_b, confidence_c, confidence_d
  input  logic [rgtd_pkg::InW-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // pi_code, group_code, traffic_flags, program_type, errored_block_count,
  // ps_text, ps_seen, change_flags, slice_index, radiotext_slice,
  // radiotext_seen_slice, zero pad
  output logic [rgtd_pkg::OutW-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast
);

  `include "assert_macros.svh"

  localparam int CW   = CONF_BITS;
  localparam int QB   = CW + 2;
  localparam int QW   = CW + 4;
  localparam int DCW  = $clog2(CW + 1);
  localparam int TMW  = 64 + 8 * QW;
  localparam logic [QB-1:0] QErr = QB'(1) << (CW - 2);
  localparam logic [QB-1:0] QOk  = QB'(2) << CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MRG  = 3'd2;
  localparam logic [2:0] S_P1   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] st_q, st_d;

  // latched group
  logic [15:0] blk_a_q, blk_b_q, blk_c_q, blk_d_q, corr_q;
  logic [3:0]  rx_q, err_q;

  // dividers, lanes for blocks B, C, D
  logic [CW-1:0]  num_q [3];
  logic [3:0]     rem_q [3];
  logic [DCW-1:0] div_cnt_q;

  // header state
  logic [15:0] pi_q;
  logic        pi_vld_q;
  logic [4:0]  gcode_q, pty_q;
  logic        tp_q, ta_q;
  logic [1:0]  ab_q;

  // name state
  rgtd_pkg::char_t nch_q [8];
  logic [3:0]      nseen_q;
  logic [QW-1:0]   nq_q [4];
  rgtd_pkg::char_t rn_q [8];
  rgtd_pkg::char_t rnp_q [8];

  // text state
  logic [7:0]      seen_q [rgtd_pkg::Rows];
  logic [7:0]      rt_vld_q, pv_vld_q;
  logic            tdo_q;
  logic [2:0]      trow_q;
  logic [7:0]      tmask_q;
  rgtd_pkg::char_t tch_q [8];
  logic [QW-1:0]   tq_q;

  // pass state
  logic [3:0] row_q;
  logic       c_found_q, c_gap_q, c_nons_q, c_stop_q, c_diff_q, c_pvd_q, tc0_q, ended_q;
  logic [3:0] flags_q;

  // memories
  logic [TMW-1:0] tm_mem [rgtd_pkg::Rows];
  logic [63:0]    rt_mem [rgtd_pkg::Rows];
  logic [63:0]    pv_mem [rgtd_pkg::Rows];
  logic [TMW-1:0] tm_rd_q;
  logic [63:0]    rt_rd_q, pv_rd_q;
  logic           tm_re, tm_we, rt_re, rt_we, pv_re, pv_we;
  logic [2:0]     tm_raddr, tm_waddr, rt_raddr, rt_waddr, pv_raddr, pv_waddr;
  logic [TMW-1:0] tm_wdata;
  logic [63:0]    rt_wdata, pv_wdata;

  // output register
  logic [rgtd_pkg::OutW-1:0] out_q;
  logic                      out_vld_q, out_last_q;

  logic in_acc;
  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------- divider step
  logic [4:0]    dv [3];
  logic [4:0]    dr [3];
  logic          dbit [3];
  logic [3:0]    drem [3];
  logic [QB-1:0] bq [3];
  logic          us [4];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv[l]   = 5'd1 + 5'(corr_q[4*(l+1) +: 4]);
      dr[l]   = {rem_q[l], num_q[l][CW-1]};
      dbit[l] = (dr[l] >= dv[l]);
      drem[l] = dbit[l] ? 4'(dr[l] - dv[l]) : dr[l][3:0];
      bq[l]   = rx_q[l+1] ? (QB'(num_q[l]) + (err_q[l+1] ? QErr : QOk)) : '0;
    end
    for (int b = 0; b < 4; b++) begin
      us[b] = rx_q[b] && (!err_q[b] || (corr_q[4*b +: 4] != 4'd0));
    end
  end

  // ---------------- merge step
  logic [3:0]      typ, seg4;
  logic            verb, abit, flip;
  logic [QW-1:0]   q2, q3;
  rgtd_pkg::char_t nc0, nc1;
  logic [1:0]      nseg;
  logic            nsn, nsame, ndo;
  rgtd_pkg::char_t nn [8];
  logic [3:0]      nlen;
  logic            nfnd, nkeep;
  logic [3:0]      nseen_d;
  logic            tdo_d;
  logic [2:0]      trow_d;
  logic [7:0]      tmask_d;
  rgtd_pkg::char_t tch_d [8];
  rgtd_pkg::char_t raw4 [4];

  always_comb begin
    typ  = blk_b_q[15:12];
    verb = blk_b_q[11];
    abit = blk_b_q[4];
    seg4 = blk_b_q[3:0];
    q2   = QW'(bq[0]) + QW'(bq[2]);
    q3   = q2 + QW'(bq[1]);
    flip = (typ == rgtd_pkg::GrpRt) && (!ab_q[1] || (ab_q[0] != abit));

    nseg  = blk_b_q[1:0];
    nc0   = rgtd_pkg::clean_char(blk_d_q[15:8]);
    nc1   = rgtd_pkg::clean_char(blk_d_q[7:0]);
    nsn   = nseen_q[nseg];
    nsame = nsn && (nch_q[{nseg, 1'b0}] == nc0) && (nch_q[{nseg, 1'b1}] == nc1);
    ndo   = (typ == rgtd_pkg::GrpPs) && us[1] && us[3] &&
            !(nsn && !nsame && (q2 < nq_q[nseg]));
    nseen_d = nseen_q;
    for (int i = 0; i < 8; i++) nn[i] = nch_q[i];
    if (ndo) begin
      nn[{nseg, 1'b0}] = nc0;
      nn[{nseg, 1'b1}] = nc1;
      nseen_d[nseg]    = 1'b1;
    end
    nlen = 4'd8;
    nfnd = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!nfnd && nn[i] == rgtd_pkg::ChNul) begin
        nlen = 4'(i);
        nfnd = 1'b1;
      end
    end
    nkeep = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (4'(i) < nlen) begin
        if (nkeep && nn[i] == rgtd_pkg::ChSpace) begin
          nn[i] = rgtd_pkg::ChNul;
        end else begin
          nkeep = 1'b0;
        end
      end
    end

    raw4[0] = blk_c_q[15:8];
    raw4[1] = blk_c_q[7:0];
    raw4[2] = blk_d_q[15:8];
    raw4[3] = blk_d_q[7:0];
    tdo_d  = (typ == rgtd_pkg::GrpRt) && us[1] && us[3] && (verb || us[2]);
    trow_d = verb ? {1'b0, seg4[3:2]} : seg4[3:1];
    for (int j = 0; j < 8; j++) begin
      if (verb) begin
        tmask_d[j] = (3'(j) >> 1) == {1'b0, seg4[1:0]};
        tch_d[j]   = rgtd_pkg::clean_char(raw4[{1'b1, 1'(j)}]);
      end else begin
        tmask_d[j] = ((3'(j) >> 2) == {2'b0, seg4[0]});
        tch_d[j]   = rgtd_pkg::clean_char(raw4[2'(j)]);
      end
    end
  end

  // ---------------- first pass: merge, scan, preview
  logic [2:0]      prow;
  logic            p1_proc;
  rgtd_pkg::char_t rc [8];
  logic [QW-1:0]   rq [8];
  rgtd_pkg::char_t cur [8];
  rgtd_pkg::char_t nch [8];
  logic [QW-1:0]   nq [8];
  logic [7:0]      ns;
  logic            lwr;
  rgtd_pkg::char_t rtc, pvc, tpv;
  logic            s_found, s_gap, s_nons, s_stop, s_diff, s_pvd;

  always_comb begin
    prow    = row_q[2:0] - 3'd1;
    p1_proc = (row_q != 4'd0);
    s_found = c_found_q;
    s_gap   = c_gap_q;
    s_nons  = c_nons_q;
    s_stop  = c_stop_q;
    s_diff  = c_diff_q;
    s_pvd   = c_pvd_q;
    pv_wdata = '0;
    for (int j = 0; j < 8; j++) begin
      rc[j]  = tm_rd_q[8*j +: 8];
      rq[j]  = tm_rd_q[64 + QW*j +: QW];
      cur[j] = seen_q[prow][j] ? rc[j] : rgtd_pkg::ChNul;
      lwr    = tdo_q && (prow == trow_q) && tmask_q[j] &&
               !(seen_q[prow][j] && (cur[j] != tch_q[j]) && (tq_q < rq[j]));
      nch[j] = lwr ? tch_q[j] : cur[j];
      ns[j]  = seen_q[prow][j] | lwr;
      nq[j]  = (lwr && (!seen_q[prow][j] || (tq_q > rq[j]))) ? tq_q : rq[j];
      if (!s_found) begin
        if (!ns[j]) begin
          s_gap = 1'b1;
        end else if (nch[j] == rgtd_pkg::ChNul) begin
          s_found = 1'b1;
        end else if (nch[j] != rgtd_pkg::ChSpace) begin
          s_nons = 1'b1;
        end
      end
      rtc = rt_vld_q[prow] ? rt_rd_q[63-8*j -: 8] : rgtd_pkg::ChNul;
      if (!s_stop) begin
        if (rtc != nch[j]) begin
          s_diff = 1'b1;
          s_stop = 1'b1;
        end else if (rtc == rgtd_pkg::ChNul) begin
          s_stop = 1'b1;
        end
      end
      pvc = pv_vld_q[prow] ? pv_rd_q[63-8*j -: 8] : rgtd_pkg::ChNul;
      tpv = !ns[j] ? rgtd_pkg::ChDot :
            (nch[j] == rgtd_pkg::ChNul ? rgtd_pkg::ChSpace : nch[j]);
      if (tpv != pvc) s_pvd = 1'b1;
      pv_wdata[63-8*j -: 8] = tpv;
    end
    tm_wdata = '0;
    for (int j = 0; j < 8; j++) begin
      tm_wdata[8*j +: 8]       = nch[j];
      tm_wdata[64 + QW*j +: QW] = nq[j];
    end
  end

  // ---------------- finish: name flags
  rgtd_pkg::char_t nprev [8];
  rgtd_pkg::char_t rn_d [8];
  logic            f_stop, f_diff, f_end, f_pvd;

  always_comb begin
    f_stop = 1'b0;
    f_diff = 1'b0;
    f_end  = 1'b0;
    f_pvd  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!f_stop) begin
        if (rn_q[i] != nch_q[i]) begin
          f_diff = 1'b1;
          f_stop = 1'b1;
        end else if (rn_q[i] == rgtd_pkg::ChNul) begin
          f_stop = 1'b1;
        end
      end
      if (nch_q[i] == rgtd_pkg::ChNul) f_end = 1'b1;
      rn_d[i]  = f_end ? rgtd_pkg::ChNul : nch_q[i];
      nprev[i] = (nseen_q[i/2] && nch_q[i] != rgtd_pkg::ChNul) ? nch_q[i] : rgtd_pkg::ChDot;
      if (nprev[i] != rnp_q[i]) f_pvd = 1'b1;
    end
  end

  // ---------------- emit
  logic            em_load, em_end;
  logic [63:0]     em_slice, em_ps;
  logic [7:0]      em_seen;
  rgtd_pkg::char_t ec;
  logic [2:0]      errs;

  always_comb begin
    em_load  = (st_q == S_EMIT) && (!out_vld_q || m_axis_tready);
    em_end   = ended_q;
    rt_wdata = '0;
    em_slice = '0;
    em_seen  = '0;
    em_ps    = '0;
    for (int j = 0; j < 8; j++) begin
      ec = seen_q[row_q[2:0]][j] ? tm_rd_q[8*j +: 8] : rgtd_pkg::ChNul;
      em_slice[63-8*j -: 8] = ec;
      em_seen[7-j]          = seen_q[row_q[2:0]][j];
      if (ec == rgtd_pkg::ChNul) em_end = 1'b1;
      rt_wdata[63-8*j -: 8] = em_end ? rgtd_pkg::ChNul : ec;
      em_ps[63-8*j -: 8]    = nch_q[j];
    end
    errs = 3'(err_q[0]) + 3'(err_q[1]) + 3'(err_q[2]) + 3'(err_q[3]);
  end

  // ---------------- memory ports
  always_comb begin
    tm_re    = ((st_q == S_P1) && !row_q[3]) || (st_q == S_RD);
    tm_raddr = row_q[2:0];
    tm_we    = (st_q == S_P1) && p1_proc;
    tm_waddr = prow;
    rt_re    = (st_q == S_P1) && !row_q[3];
    rt_raddr = row_q[2:0];
    rt_we    = em_load && flags_q[1];
    rt_waddr = row_q[2:0];
    pv_re    = rt_re;
    pv_raddr = row_q[2:0];
    pv_we    = tm_we;
    pv_waddr = prow;
  end

  always_ff @(posedge clk_i) begin
    if (tm_we) tm_mem[tm_waddr] <= tm_wdata;
    if (tm_re) tm_rd_q <= tm_mem[tm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) rt_mem[rt_waddr] <= rt_wdata;
    if (rt_re) rt_rd_q <= rt_mem[rt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    if (pv_re) pv_rd_q <= pv_mem[pv_raddr];
  end

  // ---------------- next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_acc && s_axis_tdata[64] && s_axis_tdata[65]) st_d = S_DIV;
      S_DIV:  if (div_cnt_q == DCW'(CW - 1)) st_d = S_MRG;
      S_MRG:  st_d = S_P1;
      S_P1:   if (row_q == 4'd8) st_d = S_FIN;
      S_FIN:  st_d = S_RD;
      S_RD:   st_d = S_EMIT;
      S_EMIT: if (em_load) st_d = (row_q[2:0] == 3'd7) ? S_IDLE : S_RD;
      default: st_d = S_IDLE;
    endcase
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_a_q <= s_axis_tdata[15:0];
      blk_b_q <= s_axis_tdata[31:16];
      blk_c_q <= s_axis_tdata[47:32];
      blk_d_q <= s_axis_tdata[63:48];
      rx_q    <= s_axis_tdata[67:64];
      err_q   <= s_axis_tdata[71:68];
      corr_q  <= s_axis_tdata[87:72];
      for (int l = 0; l < 3; l++) begin
        num_q[l] <= CW'(s_axis_tdata[88 + 8*l +: 8]);
        rem_q[l] <= '0;
      end
    end else if (st_q == S_DIV) begin
      for (int l = 0; l < 3; l++) begin
        num_q[l] <= {num_q[l][CW-2:0], dbit[l]};
        rem_q[l] <= drem[l];
      end
    end
    if (st_q == S_MRG) begin
      trow_q  <= trow_d;
      tmask_q <= tmask_d;
      tq_q    <= verb ? q2 : q3;
      for (int j = 0; j < 8; j++) tch_q[j] <= tch_d[j];
    end
    if (em_load) begin
      out_q <= {6'd0, em_seen, em_slice, row_q[2:0], flags_q, nseen_q, em_ps,
                errs, pty_q, ta_q, tp_q, gcode_q, pi_q};
      out_last_q <= (row_q[2:0] == 3'd7);
    end
  end

  // ---------------- control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      div_cnt_q <= '0;
      pi_q      <= '0;
      pi_vld_q  <= 1'b0;
      gcode_q   <= '0;
      pty_q     <= '0;
      tp_q      <= 1'b0;
      ta_q      <= 1'b0;
      ab_q      <= '0;
      nseen_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        nch_q[i] <= rgtd_pkg::ChNul;
        rn_q[i]  <= rgtd_pkg::ChNul;
        rnp_q[i] <= rgtd_pkg::ChNul;
      end
      for (int i = 0; i < 4; i++) nq_q[i] <= '0;
      for (int r = 0; r < rgtd_pkg::Rows; r++) seen_q[r] <= '0;
      rt_vld_q  <= '0;
      pv_vld_q  <= '0;
      tdo_q     <= 1'b0;
      row_q     <= '0;
      c_found_q <= 1'b0;
      c_gap_q   <= 1'b0;
      c_nons_q  <= 1'b0;
      c_stop_q  <= 1'b0;
      c_diff_q  <= 1'b0;
      c_pvd_q   <= 1'b0;
      tc0_q     <= 1'b0;
      ended_q   <= 1'b0;
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (em_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: div_cnt_q <= '0;
        S_DIV:  div_cnt_q <= div_cnt_q + DCW'(1);
        S_MRG: begin
          if (us[0] || !pi_vld_q) begin
            pi_vld_q <= 1'b1;
            pi_q     <= blk_a_q;
          end
          gcode_q <= {typ, verb};
          tp_q    <= blk_b_q[10];
          pty_q   <= blk_b_q[9:5];
          if (typ == rgtd_pkg::GrpPs) ta_q <= blk_b_q[4];
          if (ndo) begin
            for (int i = 0; i < 8; i++) nch_q[i] <= nn[i];
            nseen_q <= nseen_d;
            if (!nsn || q2 > nq_q[nseg]) nq_q[nseg] <= q2;
          end
          if (flip) begin
            ab_q <= {1'b1, abit};
            for (int r = 0; r < rgtd_pkg::Rows; r++) seen_q[r] <= '0;
          end
          tdo_q     <= tdo_d;
          row_q     <= '0;
          c_found_q <= 1'b0;
          c_gap_q   <= 1'b0;
          c_nons_q  <= 1'b0;
          c_stop_q  <= 1'b0;
          c_diff_q  <= 1'b0;
          c_pvd_q   <= 1'b0;
        end
        S_P1: begin
          row_q <= row_q + 4'd1;
          if (p1_proc) begin
            seen_q[prow]   <= ns;
            pv_vld_q[prow] <= 1'b1;
            c_found_q <= s_found;
            c_gap_q   <= s_gap;
            c_nons_q  <= s_nons;
            c_stop_q  <= s_stop;
            c_diff_q  <= s_diff;
            c_pvd_q   <= s_pvd;
            if (prow == 3'd0) tc0_q <= (nch[0] != rgtd_pkg::ChNul);
          end
        end
        S_FIN: begin
          flags_q[0] <= f_diff && (nch_q[0] != rgtd_pkg::ChNul);
          flags_q[1] <= !c_gap_q && c_nons_q && tc0_q && c_diff_q;
          flags_q[2] <= f_pvd;
          flags_q[3] <= c_pvd_q;
          if (f_diff && (nch_q[0] != rgtd_pkg::ChNul)) begin
            for (int i = 0; i < 8; i++) rn_q[i] <= rn_d[i];
          end
          for (int i = 0; i < 8; i++) rnp_q[i] <= nprev[i];
          row_q   <= '0;
          ended_q <= 1'b0;
        end
        S_EMIT: begin
          if (em_load) begin
            row_q   <= row_q + 4'd1;
            ended_q <= em_end;
            if (flags_q[1]) rt_vld_q[row_q[2:0]] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMP(a_last_slice, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
              m_axis_tdata[105:103] == 3'd7)
  `ASSERT_NXT(a_last_idle, clk_i, rst_ni, em_load && row_q[2:0] == 3'd7, st_q == S_IDLE)
  `ASSERT_NXT(a_flip_clear, clk_i, rst_ni, st_q == S_MRG && flip,
              seen_q[0] == 8'd0 && seen_q[7] == 8'd0)

endmodule

>>> dv/tb_top.sv
// Testbench for the RDS group text decoder: random and directed groups, slice beats checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  conf_d;
    logic [7:0]  conf_c;
    logic [7:0]  conf_b;
    logic [15:0] corr;
    logic [3:0]  err;
    logic [3:0]  rcv;
    logic [15:0] blk_d;
    logic [15:0] blk_c;
    logic [15:0] blk_b;
    logic [15:0] blk_a;
  } group_t;

  typedef struct packed {
    logic        last;
    logic [7:0]  seen_slice;
    logic [63:0] rt_slice;
    logic [2:0]  slice_idx;
    logic [3:0]  changes;
    logic [3:0]  ps_seen;
    logic [63:0] ps_text;
    logic [2:0]  errs;
    logic [4:0]  pty;
    logic [1:0]  traffic;
    logic [4:0]  grp_code;
    logic [15:0] pi;
  } slice_t;

  localparam int NumRandom = 360;
  localparam int TailItems = 40;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [rgtd_pkg::InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [rgtd_pkg::OutW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  rds_group_text_decoder_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  group_t groups_pending[$];
  slice_t slices_due[$];
  group_t cur_group;
  int total_groups = 0;
  int groups_sent = 0;
  int beats_seen = 0;
  int drain_at = 150;
  int errors = 0;
  bit tail_phase = 1'b0;
  bit long_hold_done = 1'b0;

  // decoder shadow state
  logic [15:0]     pi_held;
  bit              pi_valid;
  logic [4:0]      hdr_code;
  bit              hdr_tp, hdr_ta;
  logic [4:0]      hdr_pty;
  rgtd_pkg::char_t name_ch[8];
  logic [3:0]      name_seen;
  int              name_q[4];
  rgtd_pkg::char_t text_ch[64];
  logic [63:0]     text_seen;
  int              text_q[64];
  bit              ab_val, ab_held;
  rgtd_pkg::char_t rep_name[8], rep_text[64], prev_name[8], prev_text[64];

  task automatic clear_state();
    pi_held = '0; pi_valid = 0; hdr_code = '0; hdr_tp = 0; hdr_ta = 0; hdr_pty = '0;
    name_seen = '0; text_seen = '0; ab_val = 0; ab_held = 0;
    for (int i = 0; i < 8; i++) begin
      name_ch[i] = 0; rep_name[i] = 0; prev_name[i] = 0;
    end
    for (int i = 0; i < 4; i++) name_q[i] = 0;
    for (int i = 0; i < 64; i++) begin
      text_ch[i] = 0; text_q[i] = 0; rep_text[i] = 0; prev_text[i] = 0;
    end
  endtask

  function automatic rgtd_pkg::char_t scrub(rgtd_pkg::char_t v);
    if (v == rgtd_pkg::ChNul || v == rgtd_pkg::ChCr || v == rgtd_pkg::ChLf)
      return rgtd_pkg::ChNul;
    if (v >= rgtd_pkg::ChSpace && v <= rgtd_pkg::ChTilde) return v;
    return rgtd_pkg::ChSpace;
  endfunction

  function automatic bit usable(group_t g, int b);
    return g.rcv[b] && (!g.err[b] || g.corr[4*b +: 4] != 0);
  endfunction

  function automatic int blk_quality(group_t g, int b);
    int conf;
    if (!g.rcv[b]) return 0;
    conf = (b == 1) ? g.conf_b : (b == 2) ? g.conf_c : g.conf_d;
    return conf / (1 + g.corr[4*b +: 4]) + (g.err[b] ? 64 : 512);
  endfunction

  task automatic merge_text(int pos, rgtd_pkg::char_t raw[4], int n, int q);
    int idx;
    rgtd_pkg::char_t c;
    bit s;
    for (int i = 0; i < n; i++) begin
      idx = pos + i;
      if (idx < 64) begin
        c = scrub(raw[i]);
        s = text_seen[idx];
        if (!(s && text_ch[idx] != c && q < text_q[idx])) begin
          text_ch[idx] = c;
          text_seen[idx] = 1'b1;
          if (!s || q > text_q[idx]) text_q[idx] = q;
        end
      end
    end
  endtask

  task automatic merge_name(int seg, logic [15:0] d, int q);
    int len;
    rgtd_pkg::char_t c0, c1;
    bit s, same;
    len = 0;
    c0 = scrub(d[15:8]);
    c1 = scrub(d[7:0]);
    s = name_seen[seg];
    same = s && name_ch[2*seg] == c0 && name_ch[2*seg+1] == c1;
    if (s && !same && q < name_q[seg]) return;
    name_ch[2*seg] = c0;
    name_ch[2*seg+1] = c1;
    name_seen[seg] = 1'b1;
    if (!s || q > name_q[seg]) name_q[seg] = q;
    while (len < 8 && name_ch[len] != 0) len++;
    while (len > 0 && name_ch[len-1] == rgtd_pkg::ChSpace) begin
      name_ch[len-1] = 0;
      len--;
    end
  endtask

  function automatic bit text_done();
    int stop;
    bit found, nonspace;
    stop = 64; found = 0; nonspace = 0;
    if (text_ch[0] == 0) return 0;
    for (int i = 0; i < 64; i++) begin
      if (text_seen[i] && !found) begin
        if (text_ch[i] == 0) begin
          stop = i; found = 1;
        end else if (text_ch[i] != rgtd_pkg::ChSpace) begin
          nonspace = 1;
        end
      end
    end
    if (!found) begin
      if (text_seen != '1) return 0;
      for (int i = 0; i < 64; i++) if (text_ch[i] != rgtd_pkg::ChSpace) nonspace = 1;
    end
    for (int i = 0; i < stop; i++) if (!text_seen[i]) return 0;
    return nonspace;
  endfunction

  task automatic predict_group(group_t g);
    logic [3:0] typ;
    bit ver, ab, differs, ended;
    int q;
    rgtd_pkg::char_t raw[4];
    rgtd_pkg::char_t np[8], tp[64];
    logic [3:0] flags;
    logic [63:0] ps;
    slice_t r;
    flags = '0;
    if (!g.rcv[0] || !g.rcv[1]) return;
    if (usable(g, 0) || !pi_valid) begin
      pi_valid = 1; pi_held = g.blk_a;
    end
    typ = g.blk_b[15:12];
    ver = g.blk_b[11];
    if (typ == rgtd_pkg::GrpPs) begin
      hdr_ta = g.blk_b[4];
      if (usable(g, 1) && usable(g, 3))
        merge_name(g.blk_b[1:0], g.blk_d, blk_quality(g, 1) + blk_quality(g, 3));
    end
    if (typ == rgtd_pkg::GrpRt) begin
      ab = g.blk_b[4];
      if (!ab_held || ab_val != ab) begin
        ab_held = 1; ab_val = ab; text_seen = '0;
        for (int i = 0; i < 64; i++) begin
          text_ch[i] = 0; text_q[i] = 0;
        end
      end
      if (!ver) begin
        if (usable(g, 1) && usable(g, 2) && usable(g, 3)) begin
          raw = '{g.blk_c[15:8], g.blk_c[7:0], g.blk_d[15:8], g.blk_d[7:0]};
          q = blk_quality(g, 1) + blk_quality(g, 2) + blk_quality(g, 3);
          merge_text(g.blk_b[3:0] * 4, raw, 4, q);
        end
      end else if (usable(g, 1) && usable(g, 3)) begin
        raw = '{g.blk_d[15:8], g.blk_d[7:0], 8'h00, 8'h00};
        merge_text(g.blk_b[3:0] * 2, raw, 2, blk_quality(g, 1) + blk_quality(g, 3));
      end
    end
    hdr_code = {typ, ver};
    hdr_tp = g.blk_b[10];
    hdr_pty = g.blk_b[9:5];

    for (int i = 0; i < 8; i++)
      np[i] = (name_seen[i/2] && name_ch[i] != 0) ? name_ch[i] : rgtd_pkg::ChDot;
    for (int i = 0; i < 64; i++)
      tp[i] = text_seen[i] ? (text_ch[i] == 0 ? rgtd_pkg::ChSpace : text_ch[i])
                           : rgtd_pkg::ChDot;

    differs = 0; ended = 0;
    for (int i = 0; i < 8; i++) begin
      if (!ended && rep_name[i] != name_ch[i]) differs = 1;
      if (rep_name[i] == 0) ended = 1;
    end
    if (differs && name_ch[0] != 0) begin
      ended = 0;
      for (int i = 0; i < 8; i++) begin
        if (name_ch[i] == 0) ended = 1;
        rep_name[i] = ended ? 8'h00 : name_ch[i];
      end
      flags[0] = 1;
    end
    if (text_done()) begin
      differs = 0; ended = 0;
      for (int i = 0; i < 64; i++) begin
        if (!ended && rep_text[i] != text_ch[i]) differs = 1;
        if (rep_text[i] == 0) ended = 1;
      end
      if (differs && text_ch[0] != 0) begin
        ended = 0;
        for (int i = 0; i < 64; i++) begin
          if (text_ch[i] == 0) ended = 1;
          rep_text[i] = ended ? 8'h00 : text_ch[i];
        end
        flags[1] = 1;
      end
    end
    if (prev_name != np) begin
      prev_name = np; flags[2] = 1;
    end
    if (prev_text != tp) begin
      prev_text = tp; flags[3] = 1;
    end

    ps = '0;
    for (int i = 0; i < 8; i++) ps = {ps[55:0], name_ch[i]};
    for (int k = 0; k < 8; k++) begin
      r = '0;
      r.pi = pi_held;
      r.grp_code = hdr_code;
      r.traffic = {hdr_ta, hdr_tp};
      r.pty = hdr_pty;
      r.errs = 3'($countones(g.err));
      r.ps_text = ps;
      r.ps_seen = name_seen;
      r.changes = flags;
      r.slice_idx = 3'(k);
      for (int i = 0; i < 8; i++) begin
        r.rt_slice = {r.rt_slice[55:0], text_ch[8*k+i]};
        r.seen_slice = {r.seen_slice[6:0], text_seen[8*k+i]};
      end
      r.last = (k == 7);
      slices_due.push_back(r);
    end
  endtask

  // stimulus helpers
  bit cur_ab = 0;

  function automatic rgtd_pkg::char_t rand_char();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 8'(8'h41 + $urandom_range(25));
    if (p < 75) return rgtd_pkg::ChSpace;
    if (p < 80) return rgtd_pkg::ChCr;
    if (p < 84) return rgtd_pkg::ChNul;
    return 8'($urandom_range(255));
  endfunction

  function automatic group_t rand_group();
    group_t g;
    int p;
    logic [3:0] typ;
    logic [127:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom};
    g = rbits[rgtd_pkg::InW-1:0];
    if ($urandom_range(9) == 0) return g;
    p = $urandom_range(99);
    typ = (p < 40) ? rgtd_pkg::GrpPs : (p < 85) ? rgtd_pkg::GrpRt : 4'($urandom_range(15));
    if ($urandom_range(24) == 0) cur_ab = ~cur_ab;
    g.blk_b[15:12] = typ;
    if (typ == rgtd_pkg::GrpRt) g.blk_b[4] = cur_ab;
    g.blk_c = {rand_char(), rand_char()};
    g.blk_d = {rand_char(), rand_char()};
    g.rcv = (($urandom_range(9) == 0) ? 4'($urandom) : 4'b1111);
    if ($urandom_range(9) > 0) g.rcv[1:0] = 2'b11;
    if ($urandom_range(9) < 7) g.err = '0;
    if ($urandom_range(3) == 0) g.corr = '0;
    return g;
  endfunction

  function automatic group_t mk(logic [15:0] b, logic [15:0] c, logic [15:0] d,
                                logic [3:0] rcv, logic [3:0] err, logic [15:0] corr,
                                logic [7:0] conf);
    group_t g;
    g.blk_a = 16'hC0DE; g.blk_b = b; g.blk_c = c; g.blk_d = d;
    g.rcv = rcv; g.err = err; g.corr = corr;
    g.conf_b = conf; g.conf_c = conf; g.conf_d = conf;
    return g;
  endfunction

  // sender
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire, nv;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        predict_group(cur_group);
        groups_sent++;
        if (groups_sent >= total_groups - TailItems) tail_phase = 1;
      end
      if (!s_axis_tvalid || fire) begin
        nv = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (groups_pending.size() > 0 &&
                     !(groups_sent == drain_at && slices_due.size() != 0)) begin
          cur_group = groups_pending.pop_front();
          s_axis_tdata <= cur_group;
          nv = 1;
          if (!tail_phase && $urandom_range(5) == 0) gap_left = $urandom_range(1, 6);
        end
        s_axis_tvalid <= nv;
      end
    end
  end

  // receiver and checker
  int stall_left = 0;
  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slice_t e, a;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        a = slice_t'({m_axis_tlast, m_axis_tdata[177:0]});
        beats_seen++;
        if (slices_due.size() == 0) begin
          $error("beat with no result pending");
          errors++;
        end else begin
          e = slices_due.pop_front();
          check_field("pi_code", 64'(e.pi), 64'(a.pi));
          check_field("group_code", 64'(e.grp_code), 64'(a.grp_code));
          check_field("traffic_flags", 64'(e.traffic), 64'(a.traffic));
          check_field("program_type", 64'(e.pty), 64'(a.pty));
          check_field("errored_block_count", 64'(e.errs), 64'(a.errs));
          check_field("ps_text", e.ps_text, a.ps_text);
          check_field("ps_seen", 64'(e.ps_seen), 64'(a.ps_seen));
          check_field("change_flags", 64'(e.changes), 64'(a.changes));
          check_field("slice_index", 64'(e.slice_idx), 64'(a.slice_idx));
          check_field("radiotext_slice", e.rt_slice, a.rt_slice);
          check_field("radiotext_seen_slice", 64'(e.seen_slice), 64'(a.seen_slice));
          check_field("last_of_run", 64'(e.last), 64'(a.last));
        end
      end
      if (!long_hold_done && beats_seen >= 400) begin
        long_hold_done = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!tail_phase && $urandom_range(5) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clear_state();
    // dropped groups, missing A then missing B
    groups_pending.push_back(mk(16'h0000, 16'h4142, 16'h4344, 4'b1110, 4'b0000, 16'h0, 8'd255));
    groups_pending.push_back(mk(16'h0000, 16'h4142, 16'h4344, 4'b1101, 4'b0000, 16'h0, 8'd255));
    // PS name with trailing spaces, all four segments, 0B too
    groups_pending.push_back(mk(16'h0410, 16'h0, 16'h5241, 4'b1111, 4'b0000, 16'h0, 8'd255));
    groups_pending.push_back(mk(16'h0011, 16'h0, 16'h4449, 4'b1111, 4'b0000, 16'h0, 8'd0));
    groups_pending.push_back(mk(16'h0812, 16'h0, 16'h4F20, 4'b1111, 4'b0000, 16'h0, 8'd128));
    groups_pending.push_back(mk(16'h0013, 16'h0, 16'h2020, 4'b1111, 4'b0000, 16'h0, 8'd255));
    // lower-quality overwrite refused, then equal accepted, then noisy B not usable
    groups_pending.push_back(mk(16'h0000, 16'h0, 16'h5858, 4'b1111, 4'b1010, 16'hF0F0, 8'd1));
    groups_pending.push_back(mk(16'h0000, 16'h0, 16'h5241, 4'b1111, 4'b1111, 16'hFFFF, 8'd0));
    groups_pending.push_back(mk(16'h0000, 16'h0, 16'h5A5A, 4'b1111, 4'b0010, 16'h0000, 8'd255));
    // short radiotext ended by CR, then cleanup of control and high chars
    groups_pending.push_back(mk(16'h2000, 16'h4849, 16'h0D41, 4'b1111, 4'b0000, 16'h0, 8'd200));
    groups_pending.push_back(mk(16'h2001, 16'h7F1F, 16'hFF0A, 4'b1111, 4'b0000, 16'h0, 8'd200));
    groups_pending.push_back(mk(16'h280F, 16'h0, 16'h7E20, 4'b1111, 4'b0000, 16'h0, 8'd90));
    // A/B flip clears the store, 2A at last segment
    groups_pending.push_back(mk(16'h2010, 16'h4142, 16'h4344, 4'b1111, 4'b0000, 16'h0, 8'd255));
    groups_pending.push_back(mk(16'h201F, 16'h4142, 16'h4344, 4'b1111, 4'b0000, 16'h0, 8'd255));
    // missing C drops the 2A merge, other type touches the header only
    groups_pending.push_back(mk(16'h2011, 16'h4142, 16'h4344, 4'b1011, 4'b0000, 16'h0, 8'd255));
    groups_pending.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111, 4'b1111, 16'h0, 8'd255));
    groups_pending.push_back(mk(16'h5000, 16'h0, 16'h0, 4'b0011, 4'b0001, 16'h0, 8'd7));
    begin
      group_t g;
      g = mk(16'h2010, 16'h2020, 16'h2020, 4'b1111, 4'b0001, 16'h0000, 8'd3);
      g.blk_a = 16'h1234;
      groups_pending.push_back(g);
    end
    for (int i = 0; i < NumRandom; i++) groups_pending.push_back(rand_group());
    total_groups = groups_pending.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (groups_pending.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (slices_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d groups (directed PS/RT cases and random streams), checked %0d beats.",
             groups_sent, beats_seen);
    if (errors == 0 && slices_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
